/* rtl/lfr_pkg.sv */
// Shared types and constants for the link frame receiver.
package lfr_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_HDR  = 3'd4
    } phase_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FLAG_VALUE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_ADDRESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_KIND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUP_CONTROL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INFO_CTRL_EV = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INFO_CTRL_OD = 3'd5;

    localparam logic [7:0] FLAG_VALUE_RST   = 8'd126;
    localparam logic [7:0] EXP_ADDRESS_RST  = 8'd3;
    localparam logic       FRAME_KIND_RST   = 1'b0;
    localparam logic [7:0] SUP_CONTROL_RST  = 8'd7;
    localparam logic [7:0] INFO_CTRL_EV_RST = 8'd0;
    localparam logic [7:0] INFO_CTRL_OD_RST = 8'd64;

    localparam logic KIND_SUPERVISION = 1'b0;

    localparam int BODY_INDEX_W = 10;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

endpackage

/* rtl/link_frame_receiver.sv */
// Link frame receiver: flag hunt, header check and body XOR check, one byte per beat.
//
//  channel   | dir | handshake         | payload
//  ----------+-----+-------------------+------------------------------------------
//  s_ (rx)   | in  | s_tvalid/s_tready | s_tdata: rx_byte
//  m_ (out)  | out | m_tvalid/m_tready | m_tdata, m_tuser, m_tlast (frame_end)
//  cfg       | in  | cfg_we            | cfg_index, cfg_wdata
//
// Each byte goes through an input register and then, through the compare logic
// and the frame state update, into the output register: one byte per cycle while
// the output is not stalled. A stalled output holds its beat while the input register
// still takes one more byte. aresetn clears the frame state and the configuration
// registers to their defaults.
module link_frame_receiver #(
    parameter int MAX_BODY = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] body_byte, [17:8] body_index, [18] check_ok, [26:19] received_control,
    // [31:27] zero
    output logic [lfr_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [lfr_pkg::M_TUSER_W-1:0]       m_tuser,   // [0] body_valid, [1] frame_abort
    output logic                                m_tlast,   // frame_end

    input  logic                                cfg_we,
    input  logic [lfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lfr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_BODY + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BODY);

    // configuration
    logic [7:0] flag_value_reg;
    logic [7:0] exp_address_reg;
    logic       frame_kind_reg;
    logic [7:0] sup_control_reg;
    logic [7:0] info_ctrl_ev_reg;
    logic [7:0] info_ctrl_od_reg;

    // frame state
    lfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       held_address_reg, held_address_next;
    logic [7:0]       held_control_reg, held_control_next;
    logic [7:0]       body_xor_reg, body_xor_next;
    logic [CNT_W-1:0] body_count_reg, body_count_next;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // output stage
    logic                            out_valid_reg;
    logic                            body_valid_reg, body_valid_next;
    logic [7:0]                      body_byte_reg, body_byte_next;
    logic [lfr_pkg::BODY_INDEX_W-1:0] body_index_reg, body_index_next;
    logic                            frame_end_reg, frame_end_next;
    logic                            check_ok_reg, check_ok_next;
    logic [7:0]                      rx_control_reg, rx_control_next;
    logic                            frame_abort_reg, frame_abort_next;

    logic advance;
    logic is_flag;
    logic ctrl_match;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_value_reg   <= lfr_pkg::FLAG_VALUE_RST;
            exp_address_reg  <= lfr_pkg::EXP_ADDRESS_RST;
            frame_kind_reg   <= lfr_pkg::FRAME_KIND_RST;
            sup_control_reg  <= lfr_pkg::SUP_CONTROL_RST;
            info_ctrl_ev_reg <= lfr_pkg::INFO_CTRL_EV_RST;
            info_ctrl_od_reg <= lfr_pkg::INFO_CTRL_OD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lfr_pkg::REG_FLAG_VALUE:   flag_value_reg   <= cfg_wdata;
                lfr_pkg::REG_EXP_ADDRESS:  exp_address_reg  <= cfg_wdata;
                lfr_pkg::REG_FRAME_KIND:   frame_kind_reg   <= cfg_wdata[0];
                lfr_pkg::REG_SUP_CONTROL:  sup_control_reg  <= cfg_wdata;
                lfr_pkg::REG_INFO_CTRL_EV: info_ctrl_ev_reg <= cfg_wdata;
                lfr_pkg::REG_INFO_CTRL_OD: info_ctrl_od_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    assign is_flag = (in_byte_reg == flag_value_reg);
    assign ctrl_match = (frame_kind_reg == lfr_pkg::KIND_SUPERVISION)
                      ? (in_byte_reg == sup_control_reg)
                      : (in_byte_reg == info_ctrl_ev_reg || in_byte_reg == info_ctrl_od_reg);

    always_comb begin
        phase_next        = phase_reg;
        held_address_next = held_address_reg;
        held_control_next = held_control_reg;
        body_xor_next     = body_xor_reg;
        body_count_next   = body_count_reg;
        body_valid_next   = 1'b0;
        body_byte_next    = 8'd0;
        body_index_next   = '0;
        frame_end_next    = 1'b0;
        check_ok_next     = 1'b0;
        rx_control_next   = 8'd0;
        frame_abort_next  = 1'b0;

        unique case (phase_reg)
            lfr_pkg::PH_HUNT: begin
                if (is_flag) begin
                    phase_next = lfr_pkg::PH_FLAG;
                end
            end
            lfr_pkg::PH_FLAG: begin
                // address match wins over a flag of the same value
                if (in_byte_reg == exp_address_reg) begin
                    held_address_next = in_byte_reg;
                    phase_next        = lfr_pkg::PH_ADDR;
                end else if (!is_flag) begin
                    phase_next = lfr_pkg::PH_HUNT;
                end
            end
            lfr_pkg::PH_ADDR: begin
                if (is_flag) begin
                    phase_next = lfr_pkg::PH_FLAG;
                end else if (ctrl_match) begin
                    held_control_next = in_byte_reg;
                    phase_next        = lfr_pkg::PH_CTRL;
                end else begin
                    phase_next       = lfr_pkg::PH_HUNT;
                    frame_abort_next = 1'b1;
                end
            end
            lfr_pkg::PH_CTRL: begin
                if (is_flag) begin
                    phase_next = lfr_pkg::PH_FLAG;
                end else if (in_byte_reg == (held_address_reg ^ held_control_reg)) begin
                    body_xor_next   = 8'd0;
                    body_count_next = '0;
                    phase_next      = lfr_pkg::PH_HDR;
                end else begin
                    phase_next       = lfr_pkg::PH_HUNT;
                    frame_abort_next = 1'b1;
                end
            end
            lfr_pkg::PH_HDR: begin
                priority if (is_flag) begin
                    frame_end_next  = 1'b1;
                    rx_control_next = held_control_reg;
                    check_ok_next   = (frame_kind_reg == lfr_pkg::KIND_SUPERVISION)
                                    || (body_xor_reg == 8'd0);
                    phase_next      = lfr_pkg::PH_HUNT;
                end else if (frame_kind_reg == lfr_pkg::KIND_SUPERVISION
                             || body_count_reg == CNT_MAX) begin
                    phase_next       = lfr_pkg::PH_HUNT;
                    frame_abort_next = 1'b1;
                end else begin
                    body_valid_next = 1'b1;
                    body_byte_next  = in_byte_reg;
                    body_index_next = lfr_pkg::BODY_INDEX_W'(body_count_reg);
                    body_xor_next   = body_xor_reg ^ in_byte_reg;
                    body_count_next = body_count_reg + CNT_W'(1);
                end
            end
            default: begin
                phase_next = lfr_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= lfr_pkg::PH_HUNT;
            held_address_reg <= 8'd0;
            held_control_reg <= 8'd0;
            body_xor_reg     <= 8'd0;
            body_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg        <= phase_next;
                held_address_reg <= held_address_next;
                held_control_reg <= held_control_next;
                body_xor_reg     <= body_xor_next;
                body_count_reg   <= body_count_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            body_valid_reg  <= body_valid_next;
            body_byte_reg   <= body_byte_next;
            body_index_reg  <= body_index_next;
            frame_end_reg   <= frame_end_next;
            check_ok_reg    <= check_ok_next;
            rx_control_reg  <= rx_control_next;
            frame_abort_reg <= frame_abort_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, rx_control_reg, check_ok_reg, body_index_reg, body_byte_reg};
    assign m_tuser  = {frame_abort_reg, body_valid_reg};
    assign m_tlast  = frame_end_reg;

endmodule

/* tb/lfr_checker.sv */
// Scoreboard for the link frame receiver: byte-level frame predictor and beat compare.
`timescale 1ns / 100ps

module lfr_checker #(
    parameter int BODY_LIMIT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lfr_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [lfr_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [lfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              errors,
    output int                              outstanding
);

    typedef struct packed {
        logic                             body_valid;
        logic [7:0]                       body_byte;
        logic [lfr_pkg::BODY_INDEX_W-1:0] body_index;
        logic                             frame_end;
        logic                             check_ok;
        logic [7:0]                       received_control;
        logic                             frame_abort;
    } rx_result_t;

    // register shadow
    logic [7:0] flag_byte;
    logic [7:0] match_address;
    logic       kind_info;
    logic [7:0] sup_ctrl;
    logic [7:0] info_ctrl_a;
    logic [7:0] info_ctrl_b;

    // frame state shadow
    lfr_pkg::phase_t rx_phase;
    logic [7:0]      held_addr;
    logic [7:0]      held_ctrl;
    logic [7:0]      run_xor;
    int unsigned     run_count;

    rx_result_t  pending_frame_outputs[$];
    rx_result_t  got_beat;
    rx_result_t  want_beat;
    int          beat_no;

    function automatic rx_result_t decode_link_byte(input logic [7:0] rx);
        rx_result_t r;
        logic       ctrl_ok;
        r = '0;
        ctrl_ok = (kind_info == lfr_pkg::KIND_SUPERVISION)
                ? (rx == sup_ctrl)
                : (rx == info_ctrl_a || rx == info_ctrl_b);
        case (rx_phase)
            lfr_pkg::PH_HUNT: begin
                if (rx == flag_byte) rx_phase = lfr_pkg::PH_FLAG;
            end
            lfr_pkg::PH_FLAG: begin
                // address match takes priority over a repeated flag
                if (rx == match_address) begin
                    held_addr = rx;
                    rx_phase  = lfr_pkg::PH_ADDR;
                end else if (rx != flag_byte) begin
                    rx_phase = lfr_pkg::PH_HUNT;
                end
            end
            lfr_pkg::PH_ADDR: begin
                if (rx == flag_byte) begin
                    rx_phase = lfr_pkg::PH_FLAG;
                end else if (ctrl_ok) begin
                    held_ctrl = rx;
                    rx_phase  = lfr_pkg::PH_CTRL;
                end else begin
                    rx_phase      = lfr_pkg::PH_HUNT;
                    r.frame_abort = 1'b1;
                end
            end
            lfr_pkg::PH_CTRL: begin
                if (rx == flag_byte) begin
                    rx_phase = lfr_pkg::PH_FLAG;
                end else if (rx == (held_addr ^ held_ctrl)) begin
                    run_xor   = '0;
                    run_count = 0;
                    rx_phase  = lfr_pkg::PH_HDR;
                end else begin
                    rx_phase      = lfr_pkg::PH_HUNT;
                    r.frame_abort = 1'b1;
                end
            end
            lfr_pkg::PH_HDR: begin
                if (rx == flag_byte) begin
                    r.frame_end        = 1'b1;
                    r.received_control = held_ctrl;
                    r.check_ok         = (kind_info == lfr_pkg::KIND_SUPERVISION)
                                       || (run_xor == '0);
                    rx_phase           = lfr_pkg::PH_HUNT;
                end else if (kind_info == lfr_pkg::KIND_SUPERVISION
                             || run_count >= BODY_LIMIT) begin
                    rx_phase      = lfr_pkg::PH_HUNT;
                    r.frame_abort = 1'b1;
                end else begin
                    r.body_valid = 1'b1;
                    r.body_byte  = rx;
                    r.body_index = run_count[lfr_pkg::BODY_INDEX_W-1:0];
                    run_xor      = run_xor ^ rx;
                    run_count    = run_count + 1;
                end
            end
            default: rx_phase = lfr_pkg::PH_HUNT;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            errors        = 0;
            beat_no       = 0;
            flag_byte     = lfr_pkg::FLAG_VALUE_RST;
            match_address = lfr_pkg::EXP_ADDRESS_RST;
            kind_info     = lfr_pkg::FRAME_KIND_RST;
            sup_ctrl      = lfr_pkg::SUP_CONTROL_RST;
            info_ctrl_a   = lfr_pkg::INFO_CTRL_EV_RST;
            info_ctrl_b   = lfr_pkg::INFO_CTRL_OD_RST;
            rx_phase      = lfr_pkg::PH_HUNT;
            held_addr     = '0;
            held_ctrl     = '0;
            run_xor       = '0;
            run_count     = 0;
            pending_frame_outputs.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                beat_no++;
                got_beat.body_valid       = m_tuser[0];
                got_beat.frame_abort      = m_tuser[1];
                got_beat.body_byte        = m_tdata[7:0];
                got_beat.body_index       = m_tdata[17:8];
                got_beat.check_ok         = m_tdata[18];
                got_beat.received_control = m_tdata[26:19];
                got_beat.frame_end        = m_tlast;
                if (pending_frame_outputs.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("beat %0d: output beat with nothing pending", beat_no);
                end else begin
                    want_beat = pending_frame_outputs.pop_front();
                    if (got_beat !== want_beat) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("beat %0d mismatch (bv byte idx end ok ctl abort)",
                                     beat_no);
                            $display("  exp %0b %h %0d %0b %0b %h %0b",
                                     want_beat.body_valid, want_beat.body_byte,
                                     want_beat.body_index, want_beat.frame_end,
                                     want_beat.check_ok, want_beat.received_control,
                                     want_beat.frame_abort);
                            $display("  got %0b %h %0d %0b %0b %h %0b",
                                     got_beat.body_valid, got_beat.body_byte,
                                     got_beat.body_index, got_beat.frame_end,
                                     got_beat.check_ok, got_beat.received_control,
                                     got_beat.frame_abort);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_frame_outputs.push_back(decode_link_byte(s_tdata));
            if (cfg_we) begin
                case (cfg_index)
                    lfr_pkg::REG_FLAG_VALUE:   flag_byte     = cfg_wdata;
                    lfr_pkg::REG_EXP_ADDRESS:  match_address = cfg_wdata;
                    lfr_pkg::REG_FRAME_KIND:   kind_info     = cfg_wdata[0];
                    lfr_pkg::REG_SUP_CONTROL:  sup_ctrl      = cfg_wdata;
                    lfr_pkg::REG_INFO_CTRL_EV: info_ctrl_a   = cfg_wdata;
                    lfr_pkg::REG_INFO_CTRL_OD: info_ctrl_b   = cfg_wdata;
                    default: ;
                endcase
            end
        end
        outstanding = pending_frame_outputs.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the link frame receiver test: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module testbench;

    localparam int BODY_LIMIT   = 1024;
    localparam int IDLE_PCT     = 8;
    localparam int HOLD_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS  = 120;
    localparam logic [lfr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [lfr_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [lfr_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                           m_tlast;
    logic                           cfg_we    = 1'b0;
    logic [lfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lfr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int errors;
    int outstanding;

    bit calm_mode    = 1'b0;
    bit hold_request = 1'b0;
    int bytes_sent   = 0;

    // what the stimulus believes is programmed
    logic [7:0] cur_flag = lfr_pkg::FLAG_VALUE_RST;
    logic [7:0] cur_addr = lfr_pkg::EXP_ADDRESS_RST;
    logic       cur_kind = lfr_pkg::FRAME_KIND_RST;
    logic [7:0] cur_sup  = lfr_pkg::SUP_CONTROL_RST;
    logic [7:0] cur_even = lfr_pkg::INFO_CTRL_EV_RST;
    logic [7:0] cur_odd  = lfr_pkg::INFO_CTRL_OD_RST;

    logic [7:0] link_bytes[$];

    link_frame_receiver #(.MAX_BODY(BODY_LIMIT)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lfr_checker #(.BODY_LIMIT(BODY_LIMIT)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= calm_mode || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        if (!calm_mode && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_link_bytes();
        foreach (link_bytes[i]) send_byte(link_bytes[i]);
    endtask

    task automatic wait_until_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            lfr_pkg::REG_FLAG_VALUE:   cur_flag = value;
            lfr_pkg::REG_EXP_ADDRESS:  cur_addr = value;
            lfr_pkg::REG_FRAME_KIND:   cur_kind = value[0];
            lfr_pkg::REG_SUP_CONTROL:  cur_sup  = value;
            lfr_pkg::REG_INFO_CTRL_EV: cur_even = value;
            lfr_pkg::REG_INFO_CTRL_OD: cur_odd  = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic close_reg_writes();
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [7:0] flag_v, input logic [7:0] addr_v,
                                 input logic [7:0] kind_v, input logic [7:0] sup_v,
                                 input logic [7:0] even_v, input logic [7:0] odd_v);
        wait_until_quiet();
        write_reg(lfr_pkg::REG_FLAG_VALUE, flag_v);
        write_reg(lfr_pkg::REG_EXP_ADDRESS, addr_v);
        write_reg(lfr_pkg::REG_FRAME_KIND, kind_v);
        write_reg(lfr_pkg::REG_SUP_CONTROL, sup_v);
        write_reg(lfr_pkg::REG_INFO_CTRL_EV, even_v);
        write_reg(lfr_pkg::REG_INFO_CTRL_OD, odd_v);
        close_reg_writes();
    endtask

    // mostly well-formed frames for the current setting, with noise and damage mixed in
    task automatic send_random_frame();
        logic [7:0] addr_b;
        logic [7:0] ctrl_b;
        logic [7:0] run_x;
        logic [7:0] b;
        int         len;
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        send_byte(cur_flag);
        if ($urandom_range(0, 99) < 20) send_byte(cur_flag);
        addr_b = ($urandom_range(0, 99) < 90) ? cur_addr : 8'($urandom_range(0, 255));
        if (cur_kind == lfr_pkg::KIND_SUPERVISION) ctrl_b = cur_sup;
        else ctrl_b = $urandom_range(0, 1) ? cur_even : cur_odd;
        if ($urandom_range(0, 99) < 12) ctrl_b = 8'($urandom_range(0, 255));
        send_byte(addr_b);
        send_byte(ctrl_b);
        send_byte(($urandom_range(0, 99) < 90) ? (addr_b ^ ctrl_b)
                                                : 8'($urandom_range(0, 255)));
        if (cur_kind == lfr_pkg::KIND_SUPERVISION)
            len = ($urandom_range(0, 99) < 10) ? 1 : 0;
        else
            len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 12)
                                                : $urandom_range(13, 64);
        run_x = '0;
        for (int i = 0; i < len; i++) begin
            // last byte usually closes the XOR to zero
            if (i == len - 1 && $urandom_range(0, 99) < 60) b = run_x;
            else do b = 8'($urandom_range(0, 255));
                 while (b == cur_flag && $urandom_range(0, 99) >= 5);
            run_x ^= b;
            send_byte(b);
        end
        send_byte(($urandom_range(0, 99) < 90) ? cur_flag : 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int  rand_start;
        int  phase_start;
        bit  pressure_done;
        pressure_done = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, supervision frames: repeated flags, junk after flag,
        // bad control, bad header check, flag inside header, stray byte after header
        link_bytes = '{8'h00, 8'hFF, 8'h7E, 8'h7E, 8'h03, 8'h07, 8'h04, 8'h7E,
                       8'h7E, 8'h55, 8'h7E, 8'h03, 8'h99, 8'h7E, 8'h03, 8'h07, 8'h00,
                       8'h7E, 8'h03, 8'h7E, 8'h03, 8'h07, 8'h7E, 8'h03, 8'h07, 8'h04,
                       8'h11};
        send_link_bytes();

        // information mode: empty body, good and bad body checks
        load_settings(8'h7E, 8'h03, 8'h01, 8'h07, 8'h00, 8'h40);
        write_reg(REG_UNUSED, 8'hAA);
        close_reg_writes();
        link_bytes = '{8'h7E, 8'h03, 8'h00, 8'h03, 8'h7E,
                       8'h7E, 8'h03, 8'h40, 8'h43, 8'h11, 8'h22, 8'h33, 8'h7E,
                       8'h7E, 8'h03, 8'h40, 8'h43, 8'hFF, 8'h00, 8'h7E,
                       8'h7E, 8'h03, 8'h40, 8'h43, 8'hAA};
        send_link_bytes();
        // switch to supervision mid-body (bit 0 only counts), then close
        wait_until_quiet();
        write_reg(lfr_pkg::REG_FRAME_KIND, 8'h02);
        close_reg_writes();
        send_byte(8'h7E);
        wait_until_quiet();
        write_reg(lfr_pkg::REG_FRAME_KIND, 8'h01);
        close_reg_writes();

        rand_start = bytes_sent;
        for (int setting = 0; bytes_sent - rand_start < RANDOM_ITEMS; setting++) begin
            case (setting)
                0: load_settings(8'h7E, 8'h03, 8'h01, 8'h07, 8'h00, 8'hFF);
                1: load_settings(8'h00, 8'hFF, 8'h01, 8'h00, 8'h80, 8'h01);
                2: load_settings(8'hFF, 8'h00, 8'hFE, 8'h5A, 8'hFF, 8'h00);
                3: load_settings(8'h55, 8'h55, 8'h01, 8'hFF, 8'h0A, 8'hA0);
                default: load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            calm_mode   = (setting == 2);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS) begin
                if (setting == 1 && !pressure_done && bytes_sent - phase_start > 40) begin
                    hold_request  = 1'b1;
                    pressure_done = 1'b1;
                end
                send_random_frame();
            end
            calm_mode = 1'b0;
        end

        wait_until_quiet();
        repeat (10) @(posedge aclk);
        if (errors == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
